// ===== hdl/tws_pkg.sv =====
// Shared types, codes and helpers for the three-wire serial master.
package tws_pkg;

   // Request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // Command byte bases
   localparam logic [7:0] CMD_READ_BASE  = 8'h81;
   localparam logic [7:0] CMD_WRITE_BASE = 8'h80;

   // Bits per transaction, reset length of one pin phase and BCD saturation limit
   localparam logic [4:0] TOTAL_BITS      = 5'd16;
   localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
   localparam logic [6:0] BCD_MAX         = 7'd99;

   // Request payload
   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] reg_address;
      logic [7:0] write_value;
      logic       io_in;
   } tws_req_type;

   // Result payload
   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_drive;
      logic       io_out;
      logic       busy_res;
      logic       read_done;
      logic [7:0] read_byte;
   } tws_rsp_type;

   // Decimal to two-digit BCD, saturated at 99; tens by reciprocal multiply
   function automatic logic [7:0] to_bcd(input logic [7:0] value);
      logic [6:0]  sat;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [3:0]  ones;
      sat      = (value > {1'b0, BCD_MAX}) ? BCD_MAX : value[6:0];
      prod     = {8'd0, sat} * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {tens, 3'd0} + {2'd0, tens, 1'b0};
      ones     = 4'(sat - tens_x10);
      return {tens, ones};
   endfunction

endpackage

// ===== hdl/tws_seq.sv =====
// Pin sequencer: advances the transaction one tick per accepted request.
module tws_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tws_pkg::tws_req_type req,
   input  logic [7:0]           phase_ticks,
   output tws_pkg::tws_rsp_type rsp
);
   import tws_pkg::*;

   // Phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LOW  = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic        is_read_ff, is_read_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [15:0] out_shift_ff, out_shift_in;
   logic [7:0]  in_shift_ff, in_shift_in;
   logic [7:0]  tick_count_ff, tick_count_in;

   logic [7:0]  phase_len;
   logic [8:0]  tick_next;
   logic        phase_over;
   logic [4:0]  bit_inc;
   logic        done;
   logic        active;
   logic        drive;

   // Phase timer: a length of zero behaves as one
   assign phase_len  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
   assign tick_next  = {1'b0, tick_count_ff} + 9'd1;
   assign phase_over = (tick_next >= {1'b0, phase_len});
   assign bit_inc    = bit_count_ff + 5'd1;

   // Next state
   always_comb begin
      phase_in      = phase_ff;
      is_read_in    = is_read_ff;
      bit_count_in  = bit_count_ff;
      out_shift_in  = out_shift_ff;
      in_shift_in   = in_shift_ff;
      tick_count_in = tick_count_ff;
      done          = 1'b0;
      case (phase_ff)
         PH_LOW: begin
            tick_count_in = phase_over ? 8'd0 : tick_next[7:0];
            if (phase_over) begin
               // sample data bits while the clock is still low
               if (is_read_ff && bit_count_ff[3]) begin
                  in_shift_in = in_shift_ff | (8'(req.io_in) << bit_count_ff[2:0]);
               end
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            tick_count_in = phase_over ? 8'd0 : tick_next[7:0];
            if (phase_over) begin
               out_shift_in = {1'b0, out_shift_ff[15:1]};
               if (bit_inc >= TOTAL_BITS) begin
                  phase_in     = PH_IDLE;
                  bit_count_in = 5'd0;
                  done         = is_read_ff;
               end else begin
                  phase_in     = PH_LOW;
                  bit_count_in = bit_inc;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req.req_type == REQ_READ || req.req_type == REQ_WRITE) begin
               is_read_in = (req.req_type == REQ_READ);
               if (req.req_type == REQ_READ) begin
                  out_shift_in = {8'd0, CMD_READ_BASE | {1'b0, req.reg_address, 1'b0}};
               end else begin
                  out_shift_in = {to_bcd(req.write_value),
                                  CMD_WRITE_BASE | {1'b0, req.reg_address, 1'b0}};
               end
               in_shift_in   = 8'd0;
               bit_count_in  = 5'd0;
               tick_count_in = 8'd0;
               phase_in      = PH_LOW;
            end
         end
      endcase
   end

   // Pin levels after this tick
   assign active = (phase_in == PH_LOW) || (phase_in == PH_HIGH);
   assign drive  = active && !(is_read_in && bit_count_in[3]);

   always_comb begin
      rsp.chip_enable  = active;
      rsp.serial_clock = (phase_in == PH_HIGH);
      rsp.io_drive     = drive;
      rsp.io_out       = drive & out_shift_in[0];
      rsp.busy_res     = active;
      rsp.read_done    = done;
      rsp.read_byte    = done ? in_shift_in : 8'd0;
   end

   // State registers, advanced once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         is_read_ff    <= 1'b0;
         bit_count_ff  <= 5'd0;
         out_shift_ff  <= 16'd0;
         in_shift_ff   <= 8'd0;
         tick_count_ff <= 8'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         is_read_ff    <= is_read_in;
         bit_count_ff  <= bit_count_in;
         out_shift_ff  <= out_shift_in;
         in_shift_ff   <= in_shift_in;
         tick_count_ff <= tick_count_in;
      end
   end

   // Checks
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.read_done |-> !rsp.chip_enable && !rsp.busy_res)
      else $error("read_done while transaction active");
   a_released_low: assert property (@(posedge clock) disable iff (reset)
      !rsp.io_drive |-> !rsp.io_out)
      else $error("io_out high on released line");
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      !bit_count_ff[4])
      else $error("bit count past last bit");

endmodule

// ===== hdl/three_wire_rtc_serial_master_unit.sv =====
// A request's result is registered in the output register, or in the skid entry while the output waits.
// Throughput: one request per cycle while req_ready is high; req_ready stays high while one result waits and
//   drops while the skid entry is full, until that entry drains into the output register.
// Each request is one tick of the pin sequencer; serial timing is set by phase_ticks.
// Reset (synchronous, active high): sequencer idle, buffers empty, phase_ticks = 1.
// Top level: configuration register, sequencer and output skid buffer.
module three_wire_rtc_serial_master_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tws_pkg::tws_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tws_pkg::tws_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);
   import tws_pkg::*;

   logic [7:0]  phase_ticks_val_ff;
   logic        req_accept;
   logic        out_free;
   tws_rsp_type seq_rsp;

   logic        out_valid_ff;
   tws_rsp_type out_data_ff;
   logic        skid_valid_ff;
   tws_rsp_type skid_data_ff;

   // Phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_val_ff <= PHASE_TICKS_RST;
      end else if (csr_wr_en) begin
         phase_ticks_val_ff <= csr_wr_data;
      end
   end

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;

   tws_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (req_accept),
      .req         (req_data),
      .phase_ticks (phase_ticks_val_ff),
      .rsp         (seq_rsp)
   );

   // Output register plus skid entry
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_valid_ff <= req_accept;
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (out_free) begin
         out_data_ff <= seq_rsp;
      end else begin
         skid_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry filled while output empty");
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("request result dropped under back-pressure");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("waiting result changed or dropped");

endmodule

// ===== sim/three_wire_rtc_serial_master_unit_tb.sv =====
// Testbench for the three-wire serial master: request driver, tick predictor and checker.
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_unit_tb;
   import tws_pkg::*;

   localparam int         HOLD_CYCLES    = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] REQ_SPARE      = 2'd3;   // undefined code, acts as a tick

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_LOW, SEQ_HIGH} seq_state_e;

   // Pin sequencer predictor plus queue of expected pin snapshots
   class tws_scoreboard;
      tws_rsp_type pin_q[$];
      int          errors;
      logic [7:0]  phase_len;
      seq_state_e  seq_state;
      logic        is_read;
      logic [4:0]  bit_idx;
      logic [15:0] tx_shift;
      logic [7:0]  rx_byte;
      logic [7:0]  tick_cnt;

      function new();
         errors    = 0;
         phase_len = PHASE_TICKS_RST;
         seq_state = SEQ_IDLE;
         is_read   = 1'b0;
         bit_idx   = '0;
         tx_shift  = '0;
         rx_byte   = '0;
         tick_cnt  = '0;
      endfunction

      // A phase length of zero behaves as one
      function int eff_len();
         return (phase_len == 8'd0) ? 1 : int'(phase_len);
      endfunction

      function bit phase_elapsed();
         if (int'(tick_cnt) + 1 >= eff_len()) begin
            tick_cnt = '0;
            return 1'b1;
         end
         tick_cnt = tick_cnt + 8'd1;
         return 1'b0;
      endfunction

      // True when the next tick closes the last clock-high phase
      function bit ends_next();
         return seq_state == SEQ_HIGH && bit_idx == TOTAL_BITS - 5'd1 &&
                int'(tick_cnt) + 1 >= eff_len();
      endfunction

      // Advance the sequencer by one accepted request and queue the pin levels
      function void note_request(tws_req_type r);
         tws_rsp_type pins;
         logic        active;
         logic        drive;
         logic        done;
         int          sat;
         logic [7:0]  bcd;
         done = 1'b0;
         case (seq_state)
            SEQ_LOW: begin
               if (phase_elapsed()) begin
                  // sample while the clock is still low
                  if (is_read && bit_idx >= 5'd8 && bit_idx < TOTAL_BITS)
                     rx_byte = rx_byte | (8'(r.io_in) << bit_idx[2:0]);
                  seq_state = SEQ_HIGH;
               end
            end
            SEQ_HIGH: begin
               if (phase_elapsed()) begin
                  bit_idx  = bit_idx + 5'd1;
                  tx_shift = tx_shift >> 1;
                  if (bit_idx >= TOTAL_BITS) begin
                     seq_state = SEQ_IDLE;
                     bit_idx   = '0;
                     done      = is_read;
                  end else begin
                     seq_state = SEQ_LOW;
                  end
               end
            end
            default: begin
               // new transaction only from idle
               if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) begin
                  is_read = (r.req_type == REQ_READ);
                  sat     = (r.write_value > 8'd99) ? int'(BCD_MAX) : int'(r.write_value);
                  bcd     = 8'(((sat / 10) << 4) | (sat % 10));
                  if (is_read)
                     tx_shift = {8'h00, CMD_READ_BASE | 8'({r.reg_address, 1'b0})};
                  else
                     tx_shift = {bcd, CMD_WRITE_BASE | 8'({r.reg_address, 1'b0})};
                  rx_byte   = '0;
                  bit_idx   = '0;
                  tick_cnt  = '0;
                  seq_state = SEQ_LOW;
               end
            end
         endcase

         active            = (seq_state != SEQ_IDLE);
         drive             = active && !(is_read && bit_idx >= 5'd8);
         pins.chip_enable  = active;
         pins.serial_clock = (seq_state == SEQ_HIGH);
         pins.io_drive     = drive;
         pins.io_out       = drive & tx_shift[0];
         pins.busy_res     = active;
         pins.read_done    = done;
         pins.read_byte    = done ? rx_byte : 8'd0;
         pin_q.push_back(pins);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one received result against the oldest expectation
      function void check_result(tws_rsp_type got);
         tws_rsp_type want;
         if (pin_q.size() == 0) begin
            $error("result 0x%0h arrived with no request outstanding", got);
            errors++;
            return;
         end
         want = pin_q.pop_front();
         compare_field("chip_enable", 8'(want.chip_enable), 8'(got.chip_enable));
         compare_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
         compare_field("io_drive", 8'(want.io_drive), 8'(got.io_drive));
         compare_field("io_out", 8'(want.io_out), 8'(got.io_out));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("read_done", 8'(want.read_done), 8'(got.read_done));
         compare_field("read_byte", want.read_byte, got.read_byte);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tws_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tws_rsp_type rsp_data;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   tws_scoreboard sb;
   bit            sender_idles;
   bit            sink_stalls;
   bit            long_hold;
   int            idle_cycles;

   three_wire_rtc_serial_master_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request, with an optional idle burst first; returns once accepted
   task automatic send_request(input tws_req_type r);
      int n;
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 18);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   // Stop offering and wait until every queued result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pin_q.size() != 0);
   endtask

   task automatic set_phase_ticks(input logic [7:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.phase_len = value;
   endtask

   // Starts are likely when idle; while busy mostly ticks, some ignored starts
   function automatic tws_req_type random_request();
      tws_req_type r;
      int          pick;
      r.reg_address = 6'($urandom);
      r.write_value = $urandom_range(0, 1) ? 8'($urandom_range(0, 99)) : 8'($urandom);
      r.io_in       = 1'($urandom);
      pick          = $urandom_range(0, 19);
      if (sb.seq_state == SEQ_IDLE)
         r.req_type = (pick < 9) ? REQ_READ : (pick < 18) ? REQ_WRITE :
                      (pick == 18) ? REQ_TICK : REQ_SPARE;
      else
         r.req_type = (pick < 17) ? REQ_TICK : (pick == 17) ? REQ_READ :
                      (pick == 18) ? REQ_WRITE : REQ_SPARE;
      return r;
   endfunction

   // One full transaction; io_mode 0 low, 1 high, 2 random data line.
   // A write start lands mid-transaction and a read start on the closing tick.
   task automatic run_transaction(input logic [1:0] kind, input logic [5:0] addr,
                                  input logic [7:0] value, input int io_mode);
      tws_req_type r;
      int          k;
      r = '{req_type: kind, reg_address: addr, write_value: value,
            io_in: (io_mode == 2) ? 1'($urandom) : 1'(io_mode)};
      send_request(r);
      k = 0;
      while (sb.seq_state != SEQ_IDLE) begin
         r.req_type = (k == 3) ? REQ_WRITE : REQ_TICK;
         if (sb.ends_next())
            r.req_type = REQ_READ;
         r.io_in = (io_mode == 2) ? 1'($urandom) : 1'(io_mode);
         send_request(r);
         k++;
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   // Result sink: random stall bursts, plus one long hold when asked
   initial begin : rsp_sink
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      tws_req_type r;
      sb           = new();
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
      long_hold    = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset phase length, address and value extremes, idle ticks
      r = '{req_type: REQ_TICK, reg_address: 6'd63, write_value: 8'd255, io_in: 1'b1};
      send_request(r);
      r.req_type = REQ_SPARE;
      send_request(r);
      run_transaction(REQ_READ, 6'd0, 8'd0, 1);
      run_transaction(REQ_READ, 6'd63, 8'd255, 0);
      run_transaction(REQ_WRITE, 6'd63, 8'd255, 2);
      run_transaction(REQ_WRITE, 6'd0, 8'd0, 1);
      run_transaction(REQ_WRITE, 6'd21, 8'd99, 0);
      run_transaction(REQ_WRITE, 6'd42, 8'd100, 2);
      run_transaction(REQ_READ, 6'd42, 8'd0, 2);

      // Random phases across phase lengths
      set_phase_ticks(8'd2);
      run_random(120);

      sender_idles = 1'b0;
      sink_stalls  = 1'b0;
      set_phase_ticks(8'd0);
      run_random(120);

      // Longest phase length: one full phase and part of the next
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
      set_phase_ticks(8'd255);
      run_random(300);

      // Long sink hold while requests keep coming, then a full drain
      set_phase_ticks(8'd3);
      run_random(60);
      long_hold = 1'b1;
      run_random(60);
      drain();

      set_phase_ticks(8'd1);
      run_random(140);

      set_phase_ticks(8'd4);
      run_random(80);

      // Closing stretch with no idling on either side
      sender_idles = 1'b0;
      sink_stalls  = 1'b0;
      set_phase_ticks(8'd1);
      run_random(140);

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pin_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
